// ===== rtl/rmw_pkg.sv =====
// ----------------------------------------------------------------------------
// rmw_pkg
// shared types and constants of the ring message writer
// ----------------------------------------------------------------------------
package rmw_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int RING_W       = $clog2(RING_BYTES);
    localparam int PREFIX_BYTES = 4;
    localparam int POS_W        = 32;
    localparam int LEN_W        = 16;
    localparam int ADDR_W       = 12;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 4;
    localparam int SUM_W        = 34;

    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 88;

    localparam int OUT_BYTE_LSB = ADDR_W;
    localparam int OUT_POS_LSB  = OUT_BYTE_LSB + BYTE_W;
    localparam int OUT_DROP_LSB = OUT_POS_LSB + POS_W;
    localparam int OUT_USED_W   = OUT_DROP_LSB + POS_W;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STORE   = 2'd0,
        KIND_PUBLISH = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TAIL_NONE    = 2'd0,
        TAIL_PUBLISH = 2'd1,
        TAIL_DROP    = 2'd2
    } tail_t;

    typedef logic [RING_W-1:0] ring_off_t;

    typedef struct packed {
        mode_t              mode;
        logic [LEN_W-1:0]   msg_len;
        logic [POS_W-1:0]   read_position;
        logic [BYTE_W-1:0]  data_byte;
    } item_t;

    // results of one item: marker stores, then prefix or payload stores, then tail
    typedef struct packed {
        tail_t              tail;
        logic [2:0]         n_a;
        logic [2:0]         n_b;
        ring_off_t          base_a;
        ring_off_t          base_b;
        logic [POS_W-1:0]   word_a;
        logic [POS_W-1:0]   word_b;
        logic [POS_W-1:0]   pub_pos;
        logic [POS_W-1:0]   drop_total;
    } plan_t;

endpackage

// ===== rtl/rmw_planner.sv =====
// ----------------------------------------------------------------------------
// rmw_planner
// producer state and per-item result plan (space check, wrap, prefix, payload)
// ----------------------------------------------------------------------------
module rmw_planner
    import rmw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  item_t             item,
    input  logic [POS_W-1:0]  padding_marker,
    output plan_t             plan
);

    logic [POS_W-1:0] wp_reg, wp_next;
    logic [POS_W-1:0] dc_reg, dc_next;
    logic [LEN_W-1:0] bl_reg, bl_next;
    ring_off_t        po_reg, po_next;
    logic             im_reg, im_next;

    logic [SUM_W-1:0] needed, used, gap, used2;
    ring_off_t        offset, base_b;
    logic             no_room1, no_room2, straddle;
    logic [POS_W-1:0] wp_wrap, wp_pref, wp_inc, dc_inc, span1, span2;
    logic [LEN_W-1:0] bl_dec;
    logic [2:0]       n_marker;

    assign needed   = SUM_W'(item.msg_len) + SUM_W'(PREFIX_BYTES);
    assign span1    = wp_reg - item.read_position;
    assign used     = SUM_W'(span1);
    assign offset   = wp_reg[RING_W-1:0];
    assign gap      = SUM_W'(RING_BYTES) - SUM_W'(offset);
    assign no_room1 = (used + needed) > SUM_W'(RING_BYTES);
    assign straddle = (SUM_W'(offset) + needed) > SUM_W'(RING_BYTES);
    assign wp_wrap  = wp_reg + gap[POS_W-1:0];
    assign span2    = wp_wrap - item.read_position;
    assign used2    = SUM_W'(span2);
    assign no_room2 = (used2 + needed) > SUM_W'(RING_BYTES);
    assign dc_inc   = (dc_reg == '1) ? dc_reg : dc_reg + POS_W'(1);
    assign n_marker = (gap >= SUM_W'(4)) ? 3'd4 : gap[2:0];
    assign base_b   = straddle ? '0 : offset;
    assign wp_pref  = (straddle ? wp_wrap : wp_reg) + POS_W'(PREFIX_BYTES);
    assign wp_inc   = wp_reg + POS_W'(1);
    assign bl_dec   = bl_reg - LEN_W'(1);

    always_comb begin
        wp_next = wp_reg;
        dc_next = dc_reg;
        bl_next = bl_reg;
        po_next = po_reg;
        im_next = im_reg;
        plan    = '0;
        plan.tail = TAIL_NONE;
        case (item.mode)
            MODE_START: begin
                if (!im_reg) begin
                    if (no_room1) begin
                        dc_next   = dc_inc;
                        plan.tail = TAIL_DROP;
                    end else begin
                        if (straddle) begin
                            plan.n_a    = n_marker;
                            plan.base_a = offset;
                            plan.word_a = padding_marker;
                            wp_next     = wp_wrap;
                        end
                        if (straddle && no_room2) begin
                            dc_next   = dc_inc;
                            plan.tail = TAIL_DROP;
                        end else begin
                            plan.n_b    = 3'd4;
                            plan.base_b = base_b;
                            plan.word_b = POS_W'(item.msg_len);
                            wp_next     = wp_pref;
                            if (item.msg_len == '0) begin
                                plan.tail    = TAIL_PUBLISH;
                                plan.pub_pos = wp_pref;
                            end else begin
                                im_next = 1'b1;
                                bl_next = item.msg_len;
                                po_next = base_b + RING_W'(PREFIX_BYTES);
                            end
                        end
                    end
                end
            end
            MODE_BYTE: begin
                if (im_reg) begin
                    plan.n_b    = 3'd1;
                    plan.base_b = po_reg;
                    plan.word_b = POS_W'(item.data_byte);
                    po_next     = po_reg + RING_W'(1);
                    wp_next     = wp_inc;
                    bl_next     = bl_dec;
                    if (bl_dec == '0) begin
                        im_next      = 1'b0;
                        plan.tail    = TAIL_PUBLISH;
                        plan.pub_pos = wp_inc;
                    end
                end
            end
            MODE_CLEAR: begin
                wp_next = '0;
                dc_next = '0;
                bl_next = '0;
                po_next = '0;
                im_next = 1'b0;
            end
            default: begin
            end
        endcase
        plan.drop_total = dc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            dc_reg <= '0;
            bl_reg <= '0;
            po_reg <= '0;
            im_reg <= 1'b0;
        end else if (take) begin
            wp_reg <= wp_next;
            dc_reg <= dc_next;
            bl_reg <= bl_next;
            po_reg <= po_next;
            im_reg <= im_next;
        end
    end

endmodule

// ===== rtl/rmw_emitter.sv =====
// ----------------------------------------------------------------------------
// rmw_emitter
// holds one result plan; results leave the output register one per unstalled cycle
// ----------------------------------------------------------------------------
module rmw_emitter
    import rmw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  plan_valid,
    input  plan_t                 plan_in,
    output logic                  plan_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    plan_t                 plan_reg, plan_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  out_load, at_last;
    logic [CNT_W-1:0]      cnt_reg, cnt_in, sub;
    kind_t                 kind;
    logic [ADDR_W-1:0]     addr;
    logic [BYTE_W-1:0]     byte_val;
    logic [POS_W-1:0]      pos;

    function automatic logic [CNT_W-1:0] count_of(input plan_t p);
        logic [CNT_W-1:0] c;
        c = CNT_W'(p.n_a) + CNT_W'(p.n_b);
        if (p.tail != TAIL_NONE) c = c + CNT_W'(1);
        return c;
    endfunction

    assign cnt_reg    = count_of(plan_reg);
    assign cnt_in     = count_of(plan_in);
    assign at_last    = (idx_reg == cnt_reg - CNT_W'(1));
    assign out_load   = !m_tvalid_reg || m_tready;
    assign plan_ready = !busy_reg || (out_load && at_last);
    assign sub        = idx_reg - CNT_W'(plan_reg.n_a);

    // result at the current index
    always_comb begin
        kind     = KIND_STORE;
        addr     = '0;
        byte_val = '0;
        pos      = '0;
        if (idx_reg < CNT_W'(plan_reg.n_a)) begin
            addr     = ADDR_W'(plan_reg.base_a + RING_W'(idx_reg[1:0]));
            byte_val = plan_reg.word_a[{idx_reg[1:0], 3'b000} +: BYTE_W];
        end else if (idx_reg < CNT_W'(plan_reg.n_a) + CNT_W'(plan_reg.n_b)) begin
            addr     = ADDR_W'(plan_reg.base_b + RING_W'(sub[1:0]));
            byte_val = plan_reg.word_b[{sub[1:0], 3'b000} +: BYTE_W];
        end else if (plan_reg.tail == TAIL_PUBLISH) begin
            kind = KIND_PUBLISH;
            pos  = plan_reg.pub_pos;
        end else begin
            kind = KIND_DROP;
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        plan_next     = plan_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = busy_reg;
            m_tdata_next  = {(M_TDATA_W - OUT_USED_W)'(0), plan_reg.drop_total, pos,
                             byte_val, addr};
            m_tuser_next  = kind;
            m_tlast_next  = at_last;
        end
        if (busy_reg && out_load) begin
            idx_next = idx_reg + CNT_W'(1);
            if (at_last) busy_next = 1'b0;
        end
        if (plan_valid && plan_ready && cnt_in != '0) begin
            busy_next = 1'b1;
            plan_next = plan_in;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg    <= plan_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/ring_message_writer_top.sv =====
// ----------------------------------------------------------------------------
// ring_message_writer_top
// producer side of a byte ring holding length-prefixed messages
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register and the emitter plan register, in
//   that order, before its first result leaves the output register
// throughput: one payload item per cycle unless the output stalls or a publish is due;
//   start items give up to nine results at that rate, set by the single output register
// reset: synchronous active low, clears positions, drop count and all valids;
//   padding marker returns to all ones
module ring_message_writer_top
    import rmw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // msg_len, read_position, data_byte
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // store_address, store_byte,
                                             // published_position, drop_total, zero pad
    output logic [1:0]            m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [POS_W-1:0]      cfg_data
);

    logic              in_valid_reg, in_valid_next;
    item_t             in_item_reg, in_item_next;
    logic [POS_W-1:0]  marker_reg, marker_next;
    logic              plan_ready, take;
    plan_t             plan;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || plan_ready;
    assign take      = in_valid_reg && plan_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        marker_next   = marker_reg;
        if (take) in_valid_next = 1'b0;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_item_next  = '{mode:          mode_t'(s_tuser),
                              msg_len:       s_tdata[15:0],
                              read_position: s_tdata[47:16],
                              data_byte:     s_tdata[55:48]};
        end
        if (cfg_valid) marker_next = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            marker_reg   <= '1;
        end else begin
            in_valid_reg <= in_valid_next;
            marker_reg   <= marker_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    rmw_planner u_planner (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .item           (in_item_reg),
        .padding_marker (marker_reg),
        .plan           (plan)
    );

    rmw_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_valid (take),
        .plan_in    (plan),
        .plan_ready (plan_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/rmw_checker.sv =====
// ----------------------------------------------------------------------------
// rmw_checker
// port level checks of the ring message writer, bound to the top level
// ----------------------------------------------------------------------------
module rmw_checker
    import rmw_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    // stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // publish and drop always close the results of an item
    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PUBLISH || m_tuser == KIND_DROP) |-> m_tlast)
        else $error("publish or drop not marked last");

    a_store_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STORE |-> m_tdata[OUT_DROP_LSB-1:OUT_POS_LSB] == '0)
        else $error("byte store carries a position");

    a_other_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STORE |-> m_tdata[OUT_POS_LSB-1:0] == '0)
        else $error("publish or drop carries a store address or byte");

endmodule

bind ring_message_writer_top rmw_checker u_rmw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/ring_message_writer_top_tb.sv =====
// ----------------------------------------------------------------------------
// ring_message_writer_top_tb
// self-checking bench for the length-prefixed ring message writer
// ----------------------------------------------------------------------------
// A queue of items, filled by the stimulus process, feeds a clocked driver.
// The driver works out the expected byte stores, publishes and drops of each
// item as it goes onto the bus. A clocked monitor compares every result field
// by field. Directed messages walk the write offset up to the ring end to
// reach padding, clipped padding and exact fits. Random messages then run
// under three sender and receiver idling patterns, with a long receiver hold.
// ----------------------------------------------------------------------------
module ring_message_writer_top_tb;
    import rmw_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LEN_W-1:0]  msg_len;
        logic [POS_W-1:0]  read_position;
        logic [BYTE_W-1:0] data_byte;
    } ring_input_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  pub_pos;
        logic [POS_W-1:0]  drops;
        logic              last;
    } ring_write_t;

    typedef struct packed {
        logic [POS_W-1:0]  wp;
        logic [POS_W-1:0]  drops;
        logic [LEN_W-1:0]  left;
        logic [ADDR_W-1:0] poff;
        logic              open;
        logic [POS_W-1:0]  marker;
    } writer_state_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // msg_len, read_position, data_byte
    logic [1:0]           s_tuser = '0;    // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // store_address, store_byte,
                                           // published_position, drop_total, zero pad
    logic [1:0]           m_tuser;         // kind
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [POS_W-1:0]     cfg_data = '0;

    ring_input_t   feed_q [$];
    ring_write_t   ring_writes_due [$];
    ring_input_t   cur_item;
    ring_write_t   due;
    writer_state_t dut_model;
    writer_state_t gen_state;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    logic hold_go = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  fed_total = 0;
    int  taken_total = 0;
    int  items_effective = 0;
    int  results_seen = 0;
    int  stores_seen = 0;
    int  published_seen = 0;
    int  dropped_seen = 0;
    int  markers_written = 0;
    int  mismatch_count = 0;

    ring_message_writer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic writer_state_t writer_reset_state();
        writer_state_t st;
        st = '0;
        st.marker = '1;
        return st;
    endfunction

    function automatic ring_write_t make_write(input logic [1:0] kind, input int addr,
                                               input logic [BYTE_W-1:0] value,
                                               input logic [POS_W-1:0] pos);
        ring_write_t w;
        w = '0;
        w.kind = kind;
        w.addr = ADDR_W'(addr);
        w.value = value;
        w.pub_pos = pos;
        return w;
    endfunction

    function automatic bit short_of_room(input logic [POS_W-1:0] wp,
                                         input logic [POS_W-1:0] rd, input int needed);
        logic [POS_W-1:0] used;
        used = wp - rd;
        return (64'(used) + 64'(needed)) > 64'(RING_BYTES);
    endfunction

    // results one item causes; advances the given writer state
    function automatic int ring_advance(inout writer_state_t st, input ring_input_t it,
                                        input bit record);
        ring_write_t w [9];
        int n;
        int off;
        int needed;
        bit lost;
        n = 0;
        lost = 1'b0;
        needed = PREFIX_BYTES + int'(it.msg_len);
        if (it.mode == MODE_START && !st.open) begin
            lost = short_of_room(st.wp, it.read_position, needed);
            if (!lost) begin
                off = int'(st.wp[ADDR_W-1:0]);
                if (off + needed > RING_BYTES) begin
                    // padding marker, clipped at the ring end
                    for (int i = 0; i < PREFIX_BYTES; i++) begin
                        if (off + i < RING_BYTES) begin
                            w[n] = make_write(KIND_STORE, off + i, st.marker[8*i +: 8], '0);
                            n = n + 1;
                        end
                    end
                    st.wp = st.wp + POS_W'(RING_BYTES - off);
                    off = 0;
                    lost = short_of_room(st.wp, it.read_position, needed);
                end
            end
            if (!lost) begin
                for (int i = 0; i < PREFIX_BYTES; i++) begin
                    w[n] = make_write(KIND_STORE, (off + i) & (RING_BYTES - 1),
                                      BYTE_W'(32'(it.msg_len) >> (8 * i)), '0);
                    n = n + 1;
                end
                st.wp = st.wp + PREFIX_BYTES;
                if (it.msg_len == 0) begin
                    w[n] = make_write(KIND_PUBLISH, 0, '0, st.wp);
                    n = n + 1;
                end else begin
                    st.open = 1'b1;
                    st.left = it.msg_len;
                    st.poff = ADDR_W'((off + PREFIX_BYTES) & (RING_BYTES - 1));
                end
            end else begin
                if (st.drops != '1)
                    st.drops = st.drops + 1;
                w[n] = make_write(KIND_DROP, 0, '0, '0);
                n = n + 1;
            end
        end else if (it.mode == MODE_BYTE && st.open) begin
            w[n] = make_write(KIND_STORE, int'(st.poff), it.data_byte, '0);
            n = n + 1;
            st.poff = ADDR_W'((int'(st.poff) + 1) & (RING_BYTES - 1));
            st.wp = st.wp + 1;
            st.left = st.left - LEN_W'(1);
            if (st.left == 0) begin
                st.open = 1'b0;
                w[n] = make_write(KIND_PUBLISH, 0, '0, st.wp);
                n = n + 1;
            end
        end else if (it.mode == MODE_CLEAR) begin
            st.wp = '0;
            st.drops = '0;
            st.left = '0;
            st.poff = '0;
            st.open = 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            w[k].drops = st.drops;
            w[k].last = (k == n - 1);
            if (record)
                ring_writes_due.push_back(w[k]);
        end
        return n;
    endfunction

    task automatic flag_mismatch(input string what, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    // driver: when the slot is free, the next queued item goes on the bus unless it idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            dut_model = writer_reset_state();
        end else begin
            if (s_tvalid && s_tready)
                taken_total++;
            if (!s_tvalid || s_tready) begin
                if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = feed_q.pop_front();
                    void'(ring_advance(dut_model, cur_item, 1'b1));
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_item.data_byte, cur_item.read_position,
                                cur_item.msg_len};
                    s_tuser <= cur_item.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (ring_writes_due.size() == 0) begin
                flag_mismatch("kind of a result with nothing pending", m_tuser, '0);
            end else begin
                due = ring_writes_due.pop_front();
                if (m_tuser !== due.kind)
                    flag_mismatch("kind", m_tuser, due.kind);
                if (m_tdata[ADDR_W-1:0] !== due.addr)
                    flag_mismatch("store_address", m_tdata[ADDR_W-1:0], due.addr);
                if (m_tdata[OUT_BYTE_LSB +: BYTE_W] !== due.value)
                    flag_mismatch("store_byte", m_tdata[OUT_BYTE_LSB +: BYTE_W], due.value);
                if (m_tdata[OUT_POS_LSB +: POS_W] !== due.pub_pos)
                    flag_mismatch("published_position", m_tdata[OUT_POS_LSB +: POS_W],
                                  due.pub_pos);
                if (m_tdata[OUT_DROP_LSB +: POS_W] !== due.drops)
                    flag_mismatch("drop_total", m_tdata[OUT_DROP_LSB +: POS_W], due.drops);
                if (m_tlast !== due.last)
                    flag_mismatch("last", m_tlast, due.last);
            end
            case (m_tuser)
                KIND_STORE:   stores_seen++;
                KIND_PUBLISH: published_seen++;
                KIND_DROP:    dropped_seen++;
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles, %0d results pending",
                     cycle_count, ring_writes_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic offer(input logic [1:0] mode, input int len,
                         input logic [POS_W-1:0] rd, input logic [BYTE_W-1:0] value);
        ring_input_t it;
        it.mode = mode;
        it.msg_len = LEN_W'(len);
        it.read_position = rd;
        it.data_byte = value;
        if (ring_advance(gen_state, it, 1'b0) != 0 || mode == MODE_CLEAR)
            items_effective++;
        feed_q.push_back(it);
        fed_total++;
    endtask

    task automatic send_message(input int len, input logic [POS_W-1:0] rd, input bit noisy);
        int cut;
        offer(MODE_START, len, rd, BYTE_W'($urandom));
        cut = (noisy && $urandom_range(99) < 5) ? $urandom_range(len) : len;
        if (gen_state.open) begin
            for (int i = 0; i < cut; i++) begin
                if (noisy && $urandom_range(99) < 4)
                    offer($urandom_range(1) ? MODE_START : MODE_NONE, $urandom_range(65535),
                          $urandom, BYTE_W'($urandom));
                offer(MODE_BYTE, $urandom_range(65535), $urandom, BYTE_W'($urandom));
            end
        end
    endtask

    // filler messages with the reader caught up, until the write offset hits target
    task automatic walk_to(input int target);
        int gap;
        gap = target - int'(gen_state.wp[ADDR_W-1:0]);
        while (gap >= 5) begin
            send_message(gap > 1508 ? 1500 : gap - PREFIX_BYTES, gen_state.wp, 1'b0);
            gap = target - int'(gen_state.wp[ADDR_W-1:0]);
        end
    endtask

    task automatic random_traffic(input int count);
        int goal;
        int pick;
        int len;
        logic [POS_W-1:0] rd;
        goal = items_effective + count;
        while (items_effective < goal) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(99);
                len = len < 60 ? $urandom_range(8) :
                      len < 92 ? $urandom_range(40, 9) : $urandom_range(120, 41);
                rd = $urandom_range(99);
                if (rd < 70)
                    rd = gen_state.wp - $urandom_range(200);
                else if (rd < 90)
                    rd = gen_state.wp - $urandom_range(RING_BYTES, RING_BYTES - 300);
                else
                    rd = $urandom;
                send_message(len, rd, 1'b1);
            end else if (pick < 80) begin
                offer(MODE_BYTE, $urandom_range(65535), $urandom, BYTE_W'($urandom));
            end else if (pick < 87) begin
                offer(MODE_NONE, $urandom_range(65535), $urandom, BYTE_W'($urandom));
            end else if (pick < 90) begin
                offer(MODE_CLEAR, $urandom_range(65535), $urandom, BYTE_W'($urandom));
            end else begin
                offer(MODE_START, $urandom_range(65535), $urandom, BYTE_W'($urandom));
            end
        end
    endtask

    task automatic settle();
        while (taken_total != fed_total || ring_writes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_marker(input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_state.marker = value;
        dut_model.marker = value;
        markers_written++;
    endtask

    initial begin
        gen_state = writer_reset_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_marker('0);

        // no idling: directed cases
        send_message(0, 32'd0, 1'b0);
        offer(MODE_START, 16'hFFFF, gen_state.wp, 8'h00);
        offer(MODE_BYTE, 16'h0000, 32'h0000_0000, 8'hA7);
        offer(MODE_NONE, 16'h1234, 32'hFFFF_FFFF, 8'hFF);
        offer(MODE_START, 3, gen_state.wp, BYTE_W'($urandom));
        offer(MODE_START, 7, $urandom, BYTE_W'($urandom));
        offer(MODE_BYTE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00);
        offer(MODE_BYTE, 16'h0000, 32'h0000_0000, 8'hFF);
        offer(MODE_BYTE, 16'h5555, 32'hAAAA_AAAA, 8'h5A);
        // marker at the ring end, then too little room after the wrap
        send_message(RING_BYTES - PREFIX_BYTES, gen_state.wp, 1'b0);
        offer(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_message(2, gen_state.wp - (RING_BYTES - 6), 1'b0);
        send_message(3, gen_state.wp - (RING_BYTES - 6), 1'b0);
        send_message(0, gen_state.wp + 1, 1'b0);
        // three marker bytes clipped at the ring end
        walk_to(RING_BYTES - 3);
        send_message(5, gen_state.wp, 1'b0);
        settle();

        write_marker('1);
        send_idle_pct <= 73;
        random_traffic(75);
        settle();

        send_idle_pct <= 0;
        stall_pct <= 73;
        write_marker($urandom);
        random_traffic(50);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        send_message(80, gen_state.wp, 1'b0);
        random_traffic(20);
        settle();

        send_idle_pct <= 6;
        stall_pct <= 6;
        write_marker($urandom);
        // one marker byte, empty payload
        walk_to(RING_BYTES - 1);
        send_message(0, gen_state.wp, 1'b0);
        // full marker, accepted after the wrap
        walk_to(RING_BYTES - 96);
        send_message(200, gen_state.wp, 1'b0);
        // prefix ends exactly at the ring end
        walk_to(RING_BYTES - PREFIX_BYTES);
        send_message(0, gen_state.wp, 1'b0);
        random_traffic(75);
        settle();

        $display("%0d items sent, %0d results: %0d stores, %0d published, %0d dropped",
                 fed_total, results_seen, stores_seen, published_seen, dropped_seen);
        $display("marker written %0d times under four idling patterns", markers_written);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
